### src/tcm_pkg.sv
// Package for the track crossfade mixer: phase codes, register map, sizing constants.
// No dependencies.
`default_nettype none
package tcm_pkg;
  localparam int SampleW = 16;
  localparam int OverlapW = 20;
  localparam logic [OverlapW-1:0] OverlapReset = 20'd6000;
  localparam logic [16:0] GainOne = 17'd32768;
  localparam logic [0:0] RegOverlap = 1'b0;

  typedef enum logic [3:0] {
    PH_WAITING    = 4'b0001,
    PH_REQUESTING = 4'b0010,
    PH_CAPTURING  = 4'b0100,
    PH_MIXING     = 4'b1000
  } phase_t;
endpackage
`default_nettype wire

### src/tcm_gain_div.sv
// Radix-2 restoring divider for the chunk gain: floor(fill*32768/peak), capped at 32768.
// Depends on tcm_pkg.
`default_nettype none
module tcm_gain_div #(
  parameter int FillW = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [FillW-1:0] fill,
  input  wire logic [FillW-1:0] peak,
  output logic                  busy,
  output logic [16:0]           gain
);
  import tcm_pkg::*;
  localparam int NumW = FillW + 15;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  num;
  logic [FillW:0]   rem;
  logic [NumW-1:0]  quo;
  logic [FillW-1:0] den;
  logic [CntW-1:0]  cnt;
  logic [FillW+1:0] trial;

  assign trial = {rem, num[NumW-1]} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CntW'(NumW);
      num <= {fill, 15'd0};
      den <= peak;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[NumW-2:0], 1'b0};
      if (!trial[FillW+1]) begin
        rem <= trial[FillW:0];
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= {rem[FillW-1:0], num[NumW-1]};
        quo <= {quo[NumW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

  always_comb begin
    if (den == '0) gain = '0;
    else if (quo > NumW'(GainOne)) gain = GainOne;
    else gain = quo[16:0];
  end
endmodule
`default_nettype wire

### src/track_crossfade_mixer_unit.sv
// Track crossfade mixer top level: phase control, tail FIFO memory, blend and saturate.
// Depends on tcm_pkg and tcm_gain_div.
//
// channel | signals                                             | direction
// in      | in_valid/in_stall, sample_in, chunk_first, lengths  | to block
// out     | out_valid/out_stall, sample_out, request_next, ovf  | from block
// cfg     | APB psel/penable/pwrite/paddr/pwdata/prdata/pready  | to block
//
// Pass-through and overflow results are registered at the accepting edge; a capture
// gives no result. A mixed item is read from the store into a register, then blended
// into the output register; a mixing chunk start first waits for the serial gain divider.
// Synchronous reset; no clearing pass, store entries are read only after write.
// The output register holds while out_stall; input waits until it is free and no divide or blend is pending.
`default_nettype none
module track_crossfade_mixer_unit #(
  parameter int STORE_DEPTH = 524288,
  parameter int LEAD_MS = 2000
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [15:0]   sample_in,
  input  wire logic                 chunk_first,
  input  wire logic [31:0]          track_length_ms,
  input  wire logic [31:0]          elapsed_ms,
  input  wire logic                 next_accepted,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [15:0]        sample_out,
  output logic                      request_next,
  output logic                      store_overflow,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [1:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import tcm_pkg::*;
  localparam int AddrW = $clog2(STORE_DEPTH);
  localparam int FillW = $clog2(STORE_DEPTH + 1);
  localparam logic [1:0] OverlapAddr = 2'(4 * RegOverlap);

  logic signed [15:0] mem [STORE_DEPTH];
  logic [OverlapW-1:0] overlap_ms;
  phase_t phase;
  logic [AddrW-1:0] head_pointer;
  logic [FillW-1:0] fill_count, peak_fill;
  logic [16:0] chunk_gain;
  logic in_capture_window;

  // stage: 0 idle/accept, 1 waiting divider, 2 blend
  logic div_wait, blend_pend, div_start, div_busy;
  logic [16:0] div_gain;
  logic [FillW-1:0] div_fill;
  logic signed [15:0] cur, old;
  logic cur_req;

  assign pready = 1'b1;
  assign prdata = (paddr == OverlapAddr) ? {12'd0, overlap_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) overlap_ms <= OverlapReset;
    else if (psel && penable && pwrite && paddr == OverlapAddr) overlap_ms <= pwdata[OverlapW-1:0];
  end

  logic accept;
  assign in_stall = div_wait || blend_pend || div_start || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  logic signed [33:0] rem_t;
  logic signed [33:0] ov_lead, ov_s;
  assign rem_t = $signed({2'b0, track_length_ms}) - $signed({2'b0, elapsed_ms});
  assign ov_s = $signed({14'd0, overlap_ms});
  assign ov_lead = ov_s + 34'(LEAD_MS);

  phase_t ph_n;
  logic win_n, req_n, gstart;
  always_comb begin
    ph_n = phase;
    win_n = in_capture_window;
    req_n = 1'b0;
    gstart = 1'b0;
    if (chunk_first) begin
      win_n = 1'b0;
      case (phase)
        PH_WAITING:
          if ($signed({2'b0, track_length_ms}) > ov_lead && rem_t < ov_lead) begin
            ph_n = PH_REQUESTING; req_n = 1'b1;
          end
        PH_REQUESTING: if (next_accepted) ph_n = PH_CAPTURING;
        PH_CAPTURING:
          if (track_length_ms != '0 && rem_t < ov_s) win_n = 1'b1;
          else if (fill_count != '0) ph_n = PH_MIXING;
        PH_MIXING:
          if (fill_count != '0) begin win_n = 1'b1; gstart = 1'b1; end
          else ph_n = PH_WAITING;
        default: ph_n = PH_WAITING;
      endcase
    end
  end

  logic [AddrW:0] wsum;
  logic [AddrW-1:0] waddr;
  assign wsum = {1'b0, head_pointer} + (AddrW+1)'(fill_count);
  assign waddr = (wsum >= (AddrW+1)'(STORE_DEPTH)) ?
                 AddrW'(wsum - (AddrW+1)'(STORE_DEPTH)) : wsum[AddrW-1:0];
  logic cap_ok;
  assign cap_ok = accept && win_n && ph_n == PH_CAPTURING && fill_count < FillW'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (cap_ok) mem[waddr] <= sample_in;
    if (!div_wait && !blend_pend) old <= mem[head_pointer];
  end

  tcm_gain_div #(.FillW(FillW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .fill(div_fill), .peak(peak_fill),
    .busy(div_busy), .gain(div_gain)
  );

  logic signed [35:0] sum;
  logic signed [20:0] r;
  assign sum = $signed({{20{cur[15]}}, cur}) * $signed({19'd0, GainOne - chunk_gain})
             + $signed({{20{old[15]}}, old}) * $signed({19'd0, chunk_gain}) + 36'sd16384;
  assign r = sum[35:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAITING;
      head_pointer <= '0;
      fill_count <= '0;
      peak_fill <= '0;
      chunk_gain <= '0;
      in_capture_window <= 1'b0;
      out_valid <= 1'b0;
      div_wait <= 1'b0;
      div_start <= 1'b0;
      blend_pend <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        phase <= ph_n;
        in_capture_window <= win_n;
        if (win_n && ph_n == PH_CAPTURING) begin
          if (fill_count < FillW'(STORE_DEPTH)) begin
            fill_count <= fill_count + 1'b1;
            if (fill_count + 1'b1 > peak_fill) peak_fill <= fill_count + 1'b1;
          end else begin
            out_valid <= 1'b1; sample_out <= sample_in;
            request_next <= req_n; store_overflow <= 1'b1;
          end
        end else if (win_n && ph_n == PH_MIXING && fill_count != '0) begin
          cur <= sample_in;
          cur_req <= req_n;
          if (gstart) begin
            div_start <= 1'b1; div_wait <= 1'b1; div_fill <= fill_count;
          end
          else blend_pend <= 1'b1;
          head_pointer <= (head_pointer == AddrW'(STORE_DEPTH - 1)) ? '0 : head_pointer + 1'b1;
          fill_count <= fill_count - 1'b1;
        end else begin
          out_valid <= 1'b1; sample_out <= sample_in;
          request_next <= req_n; store_overflow <= 1'b0;
        end
      end
      if (div_wait && !div_start && !div_busy) begin
        div_wait <= 1'b0;
        chunk_gain <= div_gain;
        blend_pend <= 1'b1;
      end
      if (blend_pend) begin
        blend_pend <= 1'b0;
        out_valid <= 1'b1;
        request_next <= cur_req;
        store_overflow <= 1'b0;
        if (r > 21'sd32767) sample_out <= 16'sh7fff;
        else if (r < -21'sd32768) sample_out <= -16'sh8000;
        else sample_out <= r[15:0];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill_count <= FillW'(STORE_DEPTH))
    else $error("fill beyond depth");
  assert property (@(posedge clk) disable iff (rst) fill_count <= peak_fill)
    else $error("fill above peak");
  assert property (@(posedge clk) disable iff (rst) blend_pend |-> !div_wait)
    else $error("blend while dividing");
  assert property (@(posedge clk) disable iff (rst) chunk_gain <= GainOne)
    else $error("gain above one");
endmodule
`default_nettype wire
